@@ rtl/jtag_scan_to_mpsse_encoder_macros.svh @@
`ifndef JTAG_SCAN_TO_MPSSE_ENCODER_MACROS_SVH
`define JTAG_SCAN_TO_MPSSE_ENCODER_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define JSE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define JSE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/jse_pkg.sv @@
package jse_pkg;

  // MPSSE opcode flag bits.
  localparam logic [7:0] OP_NEGW = 8'h01;
  localparam logic [7:0] OP_BITS = 8'h02;
  localparam logic [7:0] OP_LSB  = 8'h08;
  localparam logic [7:0] OP_WTDI = 8'h10;
  localparam logic [7:0] OP_RTDO = 8'h20;
  localparam logic [7:0] OP_WTMS = 8'h40;

  // Complete opcodes used by the encoder.
  localparam logic [7:0] CMD_TMS       = OP_WTMS | OP_BITS | OP_NEGW | OP_LSB;
  localparam logic [7:0] CMD_TMS_RD    = CMD_TMS | OP_RTDO;
  localparam logic [7:0] CMD_BYTES     = OP_WTDI | OP_NEGW | OP_LSB;
  localparam logic [7:0] CMD_BYTES_RD  = CMD_BYTES | OP_RTDO;
  localparam logic [7:0] CMD_PBITS     = OP_WTDI | OP_BITS | OP_NEGW | OP_LSB;
  localparam logic [7:0] CMD_PBITS_RD  = CMD_PBITS | OP_RTDO;

  // Request and result codes.
  localparam logic CMD_FIX   = 1'b1;
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_WORD = 1'b1;

  // Field limits and fixed byte values.
  localparam logic [3:0]  LEAD_MAX      = 4'd11;
  localparam logic [6:0]  DATA_MAX      = 7'd64;
  localparam logic [3:0]  TMS_SPLIT     = 4'd8;
  localparam logic [7:0]  TMS_FIRST_LEN = 8'd6;
  localparam logic [7:0]  LAST_LEN      = 8'd1;
  localparam logic [6:0]  LAST_TMS_BITS = 7'h03;
  localparam logic [63:0] BYTE_MASK     = 64'hff;
  localparam logic [63:0] LATE_SEED     = 64'h40;
  localparam logic [7:0]  PENDING_MAX   = 8'hff;

  localparam int unsigned QUEUE_DEPTH = 2;

  // One classified request as it travels from the front to the back.
  typedef struct packed {
    logic        is_fix;
    logic [3:0]  lead_n;
    logic [11:0] lead_v;
    logic        has_data;
    logic [2:0]  nbytes;
    logic [2:0]  part;
    logic        cap;
    logic        last_bit;
    logic [63:0] word;
    logic [7:0]  pending;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic pop;
    logic busy;
  } bk_stat_t;

endpackage

@@ rtl/jse_channels.sv @@
// Request channel into the encoder.
interface jse_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [3:0]  tms_lead_bits;
  logic [10:0] tms_lead_value;
  logic [6:0]  data_bits;
  logic [63:0] data_value;
  logic        capture;
  logic [63:0] raw_reply;

  modport source (
    output valid, command, tms_lead_bits, tms_lead_value, data_bits, data_value,
           capture, raw_reply,
    input  ready
  );
  modport sink (
    input  valid, command, tms_lead_bits, tms_lead_value, data_bits, data_value,
           capture, raw_reply,
    output ready
  );
endinterface

// Result channel out of the encoder.
interface jse_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  out_byte;
  logic        last_of_run;
  logic [63:0] fixed_word;
  logic [7:0]  reply_bytes_pending;

  modport source (
    output valid, kind, out_byte, last_of_run, fixed_word, reply_bytes_pending,
    input  ready
  );
  modport sink (
    input  valid, kind, out_byte, last_of_run, fixed_word, reply_bytes_pending,
    output ready
  );
endinterface

@@ rtl/jse_front.sv @@
module jse_front (
  input  logic            clk,
  input  logic            rst_n,
  jse_in_if.sink          in_ch,
  input  jse_pkg::q_stat_t q_stat,
  output logic            push,
  output jse_pkg::job_t   job
);
  import jse_pkg::*;

  logic [7:0]  pending_r, pending_nxt;
  logic [2:0]  pbc_r, pbc_nxt;
  logic [63:0] pbm_r, pbm_nxt;
  logic [63:0] late_r, late_nxt;
  logic [63:0] top_r, top_nxt;

  logic        accept, is_fix, has_data, cap_upd, late_hit;
  logic [3:0]  lead_n, lead_tot, rwb, fix_sh;
  logic [6:0]  dbits;
  logic [11:0] lead_v;
  logic [5:0]  n;
  logic [2:0]  nbytes, part;
  logic [8:0]  sum;
  logic [7:0]  pend_enc;
  logic [63:0] hi_sh, w_part, w_fix;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign is_fix      = (in_ch.command == CMD_FIX);

  // Clamp the counts and append the generic 1-0-0 when data follows.
  always_comb begin
    lead_n   = (in_ch.tms_lead_bits > LEAD_MAX) ? LEAD_MAX : in_ch.tms_lead_bits;
    dbits    = (in_ch.data_bits > DATA_MAX) ? DATA_MAX : in_ch.data_bits;
    has_data = (dbits != 7'd0);
    lead_v   = {1'b0, in_ch.tms_lead_value};
    if (has_data) begin
      lead_v = lead_v | (12'd1 << lead_n);
    end
    lead_tot = has_data ? (lead_n + 4'd3) : lead_n;
    n        = 6'(dbits - 7'd1);
    nbytes   = n[5:3];
    part     = n[2:0];
    rwb      = {1'b0, nbytes} + {3'b000, (part != 3'd0)};
    sum      = {1'b0, pending_r} + {5'b0, rwb} + 9'd1;
    pend_enc = (sum > {1'b0, PENDING_MAX}) ? PENDING_MAX : sum[7:0];
  end

  // Re-align a raw reply word with the masks left by the last capture.
  always_comb begin
    fix_sh   = 4'd8 - {1'b0, pbc_r};
    hi_sh    = (in_ch.raw_reply & pbm_r) >> fix_sh;
    late_hit = |(in_ch.raw_reply & late_r);
    if (pbc_r != 3'd0) begin
      w_part = (in_ch.raw_reply & ~pbm_r) | (pbm_r & hi_sh);
    end else begin
      w_part = in_ch.raw_reply;
    end
    w_fix = w_part & (top_r - 64'd1);
    if (late_hit) begin
      w_fix = w_fix | top_r;
    end
  end

  // Capture bookkeeping for the next fix request.
  assign cap_upd = accept && !is_fix && has_data && in_ch.capture;

  always_comb begin
    pending_nxt = pending_r;
    pbc_nxt     = pbc_r;
    pbm_nxt     = pbm_r;
    late_nxt    = late_r;
    top_nxt     = top_r;
    if (accept && is_fix) begin
      pending_nxt = 8'd0;
    end else if (cap_upd) begin
      pending_nxt = pend_enc;
      pbc_nxt     = part;
      pbm_nxt     = (part != 3'd0) ? (BYTE_MASK << {nbytes, 3'b000}) : 64'd0;
      late_nxt    = rwb[3] ? 64'd0 : (LATE_SEED << {rwb[2:0], 3'b000});
      top_nxt     = 64'd1 << n;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 8'd0;
      pbc_r     <= 3'd0;
      pbm_r     <= 64'd0;
      late_r    <= 64'd0;
      top_r     <= 64'd0;
    end else begin
      pending_r <= pending_nxt;
      pbc_r     <= pbc_nxt;
      pbm_r     <= pbm_nxt;
      late_r    <= late_nxt;
      top_r     <= top_nxt;
    end
  end

  // An encode request with nothing to clock produces no job at all.
  assign push = accept && (is_fix || (lead_tot != 4'd0));

  always_comb begin
    job.is_fix   = is_fix;
    job.lead_n   = lead_tot;
    job.lead_v   = lead_v;
    job.has_data = has_data;
    job.nbytes   = nbytes;
    job.part     = part;
    job.cap      = in_ch.capture;
    job.last_bit = in_ch.data_value[n];
    job.word     = is_fix ? w_fix : in_ch.data_value;
    job.pending  = (!is_fix && has_data && in_ch.capture) ? pend_enc : pending_r;
  end

endmodule

@@ rtl/jse_queue.sv @@
module jse_queue #(
  parameter int unsigned DEPTH = jse_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  jse_pkg::job_t    wr_job,
  input  logic             pop,
  output jse_pkg::job_t    head,
  output jse_pkg::q_stat_t q_stat
);
  import jse_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  // Pointer advance with wrap at the last entry.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : (wr_ptr_r + PW'(1));
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : (rd_ptr_r + PW'(1));
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Job storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= wr_job;
    end
  end

  assign head         = entry_r[rd_ptr_r];
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign q_stat.empty = (count_r == '0);

endmodule

@@ rtl/jse_back.sv @@
module jse_back (
  input  logic              clk,
  input  logic              rst_n,
  input  jse_pkg::job_t     head,
  input  jse_pkg::q_stat_t  q_stat,
  output jse_pkg::bk_stat_t bk_stat,
  jse_out_if.source         out_ch
);
  import jse_pkg::*;

  typedef enum logic [6:0] {
    SEG_FIX   = 7'b0000001,
    SEG_LEADA = 7'b0000010,
    SEG_LEADB = 7'b0000100,
    SEG_BYTES = 7'b0001000,
    SEG_PART  = 7'b0010000,
    SEG_LAST  = 7'b0100000,
    SEG_TAIL  = 7'b1000000
  } seg_t;

  seg_t        seg_r, seg_nxt, seg_after, data_first, after_bytes;
  logic        active_r, active_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic        out_valid_r, out_valid_nxt;
  job_t        job_r;
  logic [63:0] data_r;
  logic        out_kind_r, out_last_r;
  logic [7:0]  out_byte_r, out_pend_r;
  logic [63:0] out_word_r;

  logic        step, pop, short_lead, seg_end, run_end, shift_data;
  logic [7:0]  byte_c;

  assign step       = active_r && (!out_valid_r || out_ch.ready);
  assign pop        = !active_r && !q_stat.empty;
  assign short_lead = (job_r.lead_n < TMS_SPLIT);

  // Order of the data segments that follow the TMS prologue.
  always_comb begin
    after_bytes = (job_r.part != 3'd0) ? SEG_PART : SEG_LAST;
    data_first  = (job_r.nbytes != 3'd0) ? SEG_BYTES : after_bytes;
  end

  // Byte for the current segment and position, and where to go next.
  always_comb begin
    byte_c     = 8'd0;
    seg_end    = (pos_r == 4'd2);
    run_end    = 1'b0;
    seg_after  = SEG_TAIL;
    shift_data = 1'b0;
    case (seg_r)
      SEG_FIX: begin
        seg_end = 1'b1;
        run_end = 1'b1;
      end
      SEG_LEADA: begin
        case (pos_r)
          4'd0:    byte_c = CMD_TMS;
          4'd1:    byte_c = short_lead ? {4'b0000, job_r.lead_n - 4'd1} : TMS_FIRST_LEN;
          default: byte_c = short_lead ? job_r.lead_v[7:0] : {1'b0, job_r.lead_v[6:0]};
        endcase
        run_end   = seg_end && short_lead && !job_r.has_data;
        seg_after = short_lead ? data_first : SEG_LEADB;
      end
      SEG_LEADB: begin
        case (pos_r)
          4'd0:    byte_c = CMD_TMS;
          4'd1:    byte_c = {4'b0000, job_r.lead_n - TMS_SPLIT};
          default: byte_c = {3'b000, job_r.lead_v[11:7]};
        endcase
        run_end   = seg_end && !job_r.has_data;
        seg_after = data_first;
      end
      SEG_BYTES: begin
        case (pos_r)
          4'd0:    byte_c = job_r.cap ? CMD_BYTES_RD : CMD_BYTES;
          4'd1:    byte_c = {5'b00000, job_r.nbytes - 3'd1};
          4'd2:    byte_c = 8'd0;
          default: begin
            byte_c     = data_r[7:0];
            shift_data = 1'b1;
          end
        endcase
        seg_end   = (pos_r == ({1'b0, job_r.nbytes} + 4'd2));
        seg_after = after_bytes;
      end
      SEG_PART: begin
        case (pos_r)
          4'd0:    byte_c = job_r.cap ? CMD_PBITS_RD : CMD_PBITS;
          4'd1:    byte_c = {5'b00000, job_r.part - 3'd1};
          default: byte_c = data_r[7:0];
        endcase
        seg_after = SEG_LAST;
      end
      SEG_LAST: begin
        case (pos_r)
          4'd0:    byte_c = job_r.cap ? CMD_TMS_RD : CMD_TMS;
          4'd1:    byte_c = LAST_LEN;
          default: byte_c = {job_r.last_bit, LAST_TMS_BITS};
        endcase
        seg_after = SEG_TAIL;
      end
      SEG_TAIL: begin
        case (pos_r)
          4'd0:    byte_c = CMD_TMS;
          default: byte_c = 8'd0;
        endcase
        run_end = seg_end;
      end
      default: begin
        seg_end = 1'b1;
        run_end = 1'b1;
      end
    endcase
  end

  // Sequencer control: load a job, then walk its segments.
  always_comb begin
    active_nxt    = active_r;
    seg_nxt       = seg_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      active_nxt = 1'b1;
      seg_nxt    = head.is_fix ? SEG_FIX : SEG_LEADA;
      pos_nxt    = 4'd0;
    end else if (step) begin
      out_valid_nxt = 1'b1;
      if (seg_end) begin
        pos_nxt = 4'd0;
        seg_nxt = seg_after;
        if (run_end) begin
          active_nxt = 1'b0;
        end
      end else begin
        pos_nxt = pos_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      seg_r       <= SEG_FIX;
      pos_r       <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      seg_r       <= seg_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Job, data shifter and output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r  <= head;
      data_r <= head.word;
    end else if (step && shift_data) begin
      data_r <= data_r >> 8;
    end
    if (step) begin
      out_kind_r <= job_r.is_fix ? KIND_WORD : KIND_BYTE;
      out_byte_r <= byte_c;
      out_last_r <= run_end;
      out_word_r <= job_r.is_fix ? job_r.word : 64'd0;
      out_pend_r <= job_r.pending;
    end
  end

  assign out_ch.valid               = out_valid_r;
  assign out_ch.kind                = out_kind_r;
  assign out_ch.out_byte            = out_byte_r;
  assign out_ch.last_of_run         = out_last_r;
  assign out_ch.fixed_word          = out_word_r;
  assign out_ch.reply_bytes_pending = out_pend_r;

  assign bk_stat.pop  = pop;
  assign bk_stat.busy = active_r;

endmodule

@@ rtl/jtag_scan_to_mpsse_encoder.sv @@
// JTAG scan request to MPSSE command byte encoder.
// in_ch takes requests with valid/ready. An encode request becomes a run of
// command bytes on out_ch (kind 0), one byte per result, last_of_run set on
// the final byte. A fix request returns one corrected reply word (kind 1)
// using the masks recorded by the most recent capturing scan.
// Throughput: the byte sequencer emits one result per cycle while out_ch
// does not stall it; a scan gives up to 25 bytes, a fix gives one word, and
// the next job is loaded from the queue once the current run has ended.
// A request that clocks nothing is taken and gives no result.
// The front accepts while the job queue (QDEPTH entries) has room, so it
// keeps taking requests while the sequencer is busy or stalled.
// When out_ch.ready is low the output register holds its result and the
// sequencer waits; the queue then fills and in_ch.ready drops.
// Reset clears the queue, the sequencer, the pending reply count and all
// re-alignment masks.
`include "jtag_scan_to_mpsse_encoder_macros.svh"

module jtag_scan_to_mpsse_encoder #(
  parameter int unsigned QDEPTH = jse_pkg::QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  jse_in_if.sink    in_ch,
  jse_out_if.source out_ch
);
  import jse_pkg::*;

  logic     push;
  job_t     fr_job;
  job_t     head;
  q_stat_t  q_stat;
  bk_stat_t bk_stat;

  // Classify requests and keep the capture bookkeeping.
  jse_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .push   (push),
    .job    (fr_job)
  );

  // Short job queue between front and sequencer.
  jse_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_job (fr_job),
    .pop    (bk_stat.pop),
    .head   (head),
    .q_stat (q_stat)
  );

  // Byte sequencer with output register.
  jse_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_stat  (q_stat),
    .bk_stat (bk_stat),
    .out_ch  (out_ch)
  );

  // Queue never written when full, never read when empty.
  `JSE_ASSERT_NOW(a_no_overflow, push, !q_stat.full, "job queue overflow")
  `JSE_ASSERT_NOW(a_no_underflow, bk_stat.pop, !q_stat.empty, "job queue underflow")
  // A loaded job keeps the sequencer busy in the following cycle.
  `JSE_ASSERT_NEXT(a_load_busy, bk_stat.pop, bk_stat.busy, "sequencer idle after load")

endmodule
